FILE: design/esc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package esc_pkg;

  // Calibration coefficient registers as seen by the datapath.
  typedef struct packed {
    logic [47:0] temp_coeffs;
    logic [63:0] press_lo;
    logic [63:0] press_hi;
    logic [47:0] press_hum;
    logic [39:0] hum;
  } esc_coef_t;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_TEMP      = 3'd0;
  localparam logic [2:0] REG_PRESS_LO  = 3'd1;
  localparam logic [2:0] REG_PRESS_HI  = 3'd2;
  localparam logic [2:0] REG_PRESS_HUM = 3'd3;
  localparam logic [2:0] REG_HUM       = 3'd4;

  // Pipeline depths, counted from the registered fine-temperature term.
  localparam int DIV_STEPS = 64;
  localparam int PRE_LAT   = 5;
  localparam int DIV_LAT   = DIV_STEPS + 2;
  localparam int POST_LAT  = 4;
  localparam int PRESS_LAT = PRE_LAT + DIV_LAT + POST_LAT;
  localparam int TH_LAT    = 7;
  localparam int ALIGN_LAT = PRESS_LAT - TH_LAT;

endpackage
`default_nettype wire

FILE: design/esc_tfine.sv
`timescale 1ns / 1ps
`default_nettype none
module esc_tfine (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      in_vld,
  input  wire  [19:0]              raw_temp,
  input  wire  [19:0]              raw_press,
  input  wire  [15:0]              raw_hum,
  input  esc_pkg::esc_coef_t       coef,
  output logic                     out_vld,
  output logic signed [31:0]       t_fine,
  output logic [19:0]              out_press,
  output logic [15:0]              out_hum
);
  import esc_pkg::*;

  logic signed [31:0] t1, t2, t3;
  logic signed [31:0] a_arg, a_mul, d, dd, b_mul_in;
  logic signed [31:0] a_mul_r, dd_r, a_r, b_mul_r, t_fine_r;
  logic [19:0] press1_r, press2_r, press3_r;
  logic [15:0] hum1_r, hum2_r, hum3_r;
  logic [2:0] vld_r;

  assign t1 = {16'b0, coef.temp_coeffs[15:0]};
  assign t2 = {{16{coef.temp_coeffs[31]}}, coef.temp_coeffs[31:16]};
  assign t3 = {{16{coef.temp_coeffs[47]}}, coef.temp_coeffs[47:32]};

  always_comb begin
    a_arg    = {15'b0, raw_temp[19:3]} - {t1[30:0], 1'b0};
    a_mul    = a_arg * t2;
    d        = {16'b0, raw_temp[19:4]} - t1;
    dd       = d * d;
    b_mul_in = (dd_r >>> 12) * t3;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[1:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    a_mul_r  <= a_mul;
    dd_r     <= dd;
    press1_r <= raw_press;
    hum1_r   <= raw_hum;
    a_r      <= a_mul_r >>> 11;
    b_mul_r  <= b_mul_in;
    press2_r <= press1_r;
    hum2_r   <= hum1_r;
    t_fine_r <= a_r + (b_mul_r >>> 14);
    press3_r <= press2_r;
    hum3_r   <= hum2_r;
  end

  assign out_vld   = vld_r[2];
  assign t_fine    = t_fine_r;
  assign out_press = press3_r;
  assign out_hum   = hum3_r;

endmodule
`default_nettype wire

FILE: design/esc_th.sv
`timescale 1ns / 1ps
`default_nettype none
module esc_th (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      in_vld,
  input  wire  signed [31:0]       t_fine,
  input  wire  [15:0]              raw_hum,
  input  esc_pkg::esc_coef_t       coef,
  output logic                     out_vld,
  output logic signed [15:0]       temp_centi,
  output logic [16:0]              hum_q22_10
);
  import esc_pkg::*;

  logic signed [31:0] h1, h2, h3, h4, h5, h6;
  logic signed [31:0] v, x_pre, m1, m2, tc, y0, y1p, xy, q, qq, r, vv;
  logic signed [15:0] tsat;
  logic signed [31:0] x1_r, m1_r, m2_r, x2_r, y0_r, x3_r, y_r, xy_r, qq_r, xy5_r;
  logic signed [31:0] r_r, xy6_r;
  logic signed [15:0] temp_r [1:TH_LAT];
  logic [16:0] hum_r;
  logic [TH_LAT-1:0] vld_r;

  assign h1 = {24'b0, coef.press_hum[23:16]};
  assign h2 = {{16{coef.press_hum[39]}}, coef.press_hum[39:24]};
  assign h3 = {24'b0, coef.press_hum[47:40]};
  assign h4 = {{16{coef.hum[15]}}, coef.hum[15:0]};
  assign h5 = {{16{coef.hum[31]}}, coef.hum[31:16]};
  assign h6 = {{24{coef.hum[39]}}, coef.hum[39:32]};

  always_comb begin
    v     = t_fine - 32'sd76800;
    x_pre = {2'b0, raw_hum, 14'b0} - (h4 <<< 20) - h5 * v + 32'sd16384;
    m1    = v * h6;
    m2    = v * h3;
    // Temperature in hundredths of a degree, saturated to 16 bits.
    tc    = (t_fine * 32'sd5 + 32'sd128) >>> 8;
    if (tc < -32'sd32768) begin
      tsat = 16'sh8000;
    end else if (tc > 32'sd32767) begin
      tsat = 16'sh7FFF;
    end else begin
      tsat = tc[15:0];
    end
    y0  = (m1_r >>> 10) * ((m2_r >>> 11) + 32'sd32768);
    y1p = ((y0_r >>> 10) + 32'sd2097152) * h2 + 32'sd8192;
    xy  = x3_r * y_r;
    q   = xy_r >>> 15;
    qq  = q * q;
    r   = (qq_r >>> 7) * h1;
    vv  = xy6_r - (r_r >>> 4);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[TH_LAT-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    x1_r  <= x_pre >>> 15;
    m1_r  <= m1;
    m2_r  <= m2;
    x2_r  <= x1_r;
    y0_r  <= y0;
    x3_r  <= x2_r;
    y_r   <= y1p >>> 14;
    xy_r  <= xy;
    qq_r  <= qq;
    xy5_r <= xy_r;
    r_r   <= r;
    xy6_r <= xy5_r;
    if (vv < 0) begin
      hum_r <= '0;
    end else if (vv > 32'sd419430400) begin
      hum_r <= 17'd102400;
    end else begin
      hum_r <= vv[28:12];
    end
  end

  always_ff @(posedge clk) begin
    temp_r[1] <= tsat;
  end

  for (genvar i = 2; i <= TH_LAT; i++) begin : g_temp
    always_ff @(posedge clk) begin
      temp_r[i] <= temp_r[i-1];
    end
  end

  assign out_vld    = vld_r[TH_LAT-1];
  assign temp_centi = temp_r[TH_LAT];
  assign hum_q22_10 = hum_r;

endmodule
`default_nettype wire

FILE: design/esc_press_pre.sv
`timescale 1ns / 1ps
`default_nettype none
module esc_press_pre (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      in_vld,
  input  wire  signed [31:0]       t_fine,
  input  wire  [19:0]              raw_press,
  input  esc_pkg::esc_coef_t       coef,
  output logic                     out_vld,
  output logic signed [63:0]       num,
  output logic signed [30:0]       den
);
  import esc_pkg::*;

  logic signed [16:0] p1;
  logic signed [15:0] p2, p3, p4, p5, p6;
  logic signed [33:0] v1;
  logic signed [67:0] sq;
  logic signed [49:0] m5, m2;
  logic signed [63:0] m5w, m2w, p4w, v2a, v1a, vb, vbs;
  logic [20:0] pdiff;
  logic signed [63:0] sq_r, v2_r, va_r, v2b_r, vb_r, num0_r, num_r;
  logic signed [49:0] m5_r, m2_r;
  logic [19:0] press1_r, press2_r, press3_r;
  logic signed [30:0] den4_r, den5_r;
  logic [PRE_LAT-1:0] vld_r;

  assign p1 = {1'b0, coef.press_lo[15:0]};
  assign p2 = coef.press_lo[31:16];
  assign p3 = coef.press_lo[47:32];
  assign p4 = coef.press_lo[63:48];
  assign p5 = coef.press_hi[15:0];
  assign p6 = coef.press_hi[31:16];

  always_comb begin
    v1    = {{2{t_fine[31]}}, t_fine} - 34'sd128000;
    sq    = v1 * v1;
    m5    = v1 * p5;
    m2    = v1 * p2;
    m5w   = m5_r;
    m2w   = m2_r;
    p4w   = p4;
    v2a   = sq_r * p6;
    v1a   = sq_r * p3;
    vb    = (va_r + 64'sh0000_8000_0000_0000) * p1;
    vbs   = vb_r >>> 33;
    pdiff = 21'd1048576 - {1'b0, press3_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[PRE_LAT-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    sq_r     <= sq[63:0];
    m5_r     <= m5;
    m2_r     <= m2;
    press1_r <= raw_press;
    v2_r     <= v2a + (m5w <<< 17) + (p4w <<< 35);
    va_r     <= (v1a >>> 8) + (m2w <<< 12);
    press2_r <= press1_r;
    vb_r     <= vb;
    v2b_r    <= v2_r;
    press3_r <= press2_r;
    // The divisor is a sign-extended 31-bit value after the shift.
    den4_r   <= vbs[30:0];
    num0_r   <= ({43'b0, pdiff} << 31) - v2b_r;
    den5_r   <= den4_r;
    num_r    <= num0_r * 64'sd3125;
  end

  assign out_vld = vld_r[PRE_LAT-1];
  assign num     = num_r;
  assign den     = den5_r;

endmodule
`default_nettype wire

FILE: design/esc_div.sv
`timescale 1ns / 1ps
`default_nettype none
module esc_div (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_vld,
  input  wire  signed [63:0]  num,
  input  wire  signed [30:0]  den,
  output logic                out_vld,
  output logic [63:0]         quo,
  output logic                den_zero
);
  import esc_pkg::*;

  // Restoring divider, one quotient bit per stage. The remainder stays below
  // the divisor magnitude, which is at most 2^30.
  logic [30:0] rem_r  [0:DIV_STEPS];
  logic [63:0] nq_r   [0:DIV_STEPS];
  logic [30:0] ad_r   [0:DIV_STEPS];
  logic        neg_r  [0:DIV_STEPS];
  logic        zero_r [0:DIV_STEPS];
  logic        vld_r  [0:DIV_STEPS];
  logic [63:0] quo_r;
  logic        zero_o_r;
  logic        vld_o_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    rem_r[0]  <= '0;
    nq_r[0]   <= num[63] ? 64'(-num) : num;
    ad_r[0]   <= den[30] ? 31'(-den) : den;
    neg_r[0]  <= num[63] ^ den[30];
    zero_r[0] <= (den == '0);
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic [31:0] trial;
    logic        ge;

    assign trial = {rem_r[k], nq_r[k][63]};
    assign ge    = (trial >= {1'b0, ad_r[k]});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else begin
        vld_r[k+1] <= vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      rem_r[k+1]  <= ge ? 31'(trial - {1'b0, ad_r[k]}) : trial[30:0];
      nq_r[k+1]   <= {nq_r[k][62:0], ge};
      ad_r[k+1]   <= ad_r[k];
      neg_r[k+1]  <= neg_r[k];
      zero_r[k+1] <= zero_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_o_r <= 1'b0;
    end else begin
      vld_o_r <= vld_r[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    quo_r    <= neg_r[DIV_STEPS] ? 64'(-nq_r[DIV_STEPS]) : nq_r[DIV_STEPS];
    zero_o_r <= zero_r[DIV_STEPS];
  end

  assign out_vld  = vld_o_r;
  assign quo      = quo_r;
  assign den_zero = zero_o_r;

endmodule
`default_nettype wire

FILE: design/esc_press_post.sv
`timescale 1ns / 1ps
`default_nettype none
module esc_press_post (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      in_vld,
  input  wire  [63:0]              quo,
  input  wire                      den_zero,
  input  esc_pkg::esc_coef_t       coef,
  output logic                     out_vld,
  output logic [31:0]              press_q24_8,
  output logic                     press_valid
);
  import esc_pkg::*;

  logic signed [15:0] p7, p8, p9;
  logic signed [63:0] p, s, t9, w2m, prod, pf, p7w;
  logic [63:0] ll_r;
  logic [31:0] lh_r, hl_r;
  logic signed [63:0] p2_r, s2_r, t9_r, w2m2_r, p3_r, w2m3_r, sum_r;
  logic [POST_LAT-2:0] zero_r;
  logic [POST_LAT-1:0] vld_r;
  logic [31:0] press_r;
  logic        pvalid_r;

  assign p7 = coef.press_hi[47:32];
  assign p8 = coef.press_hi[63:48];
  assign p9 = coef.press_hum[15:0];

  always_comb begin
    p    = quo;
    s    = p >>> 13;
    t9   = s * p9;
    w2m  = p * p8;
    // Low 64 bits of the product, assembled from 32-bit partial products.
    prod = ll_r + {32'(lh_r + hl_r), 32'b0};
    p7w  = p7;
    pf   = (sum_r >>> 8) + (p7w <<< 4);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[POST_LAT-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    p2_r   <= p;
    s2_r   <= s;
    t9_r   <= t9;
    w2m2_r <= w2m;
    ll_r   <= t9_r[31:0] * s2_r[31:0];
    lh_r   <= 32'(t9_r[31:0] * s2_r[63:32]);
    hl_r   <= 32'(t9_r[63:32] * s2_r[31:0]);
    p3_r   <= p2_r;
    w2m3_r <= w2m2_r;
    sum_r  <= p3_r + (prod >>> 25) + (w2m3_r >>> 19);
    zero_r <= {zero_r[POST_LAT-3:0], den_zero};
    pvalid_r <= !zero_r[POST_LAT-2];
    if (zero_r[POST_LAT-2] || pf < 0) begin
      press_r <= '0;
    end else if (pf[63:32] != '0) begin
      press_r <= 32'hFFFF_FFFF;
    end else begin
      press_r <= pf[31:0];
    end
  end

  assign out_vld     = vld_r[POST_LAT-1];
  assign press_q24_8 = press_r;
  assign press_valid = pvalid_r;

endmodule
`default_nettype wire

FILE: design/env_sensor_compensation_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Temperature, pressure and humidity compensation for a combined PTH sensor.
// A raw sample word is taken at every clock edge where start is high; busy is
// never raised, so one word per cycle is accepted without gaps. Each word
// produces exactly one result word, shown for a single cycle with out_valid
// high once it has passed 3 register stages for the fine-temperature term
// and then 75 on the pressure path, whose 64-stage one-bit-per-stage
// divider sets the depth.
// Results come out in the order the samples went in.
// The receiver cannot stall the block and must take each result word in the
// cycle it appears. Coefficients must be written over the APB-style port only
// while no sample is in flight, which the block does not enforce. A register
// at byte address 8 times its index reads back its last written value.
module env_sensor_compensation_unit (
  input  wire          clk,
  input  wire          rst_n,
  input  wire          start,
  output logic         busy,
  input  wire  [19:0]  in_raw_temp,
  input  wire  [19:0]  in_raw_press,
  input  wire  [15:0]  in_raw_hum,
  output logic         out_valid,
  output logic signed [15:0] out_temp_centi,
  output logic [31:0]  out_press_q24_8,
  output logic [16:0]  out_hum_q22_10,
  output logic         out_press_valid,
  input  wire          psel,
  input  wire          penable,
  input  wire          pwrite,
  input  wire  [5:0]   paddr,
  input  wire  [63:0]  pwdata,
  output logic [63:0]  prdata,
  output logic         pready
);
  import esc_pkg::*;

  logic [47:0] temp_coeffs_r;
  logic [63:0] press_lo_r;
  logic [63:0] press_hi_r;
  logic [47:0] press_hum_r;
  logic [39:0] hum_r;
  esc_coef_t   coef;
  logic        cfg_wr;
  logic [2:0]  cfg_idx;

  logic               tf_vld;
  logic signed [31:0] t_fine;
  logic [19:0]        tf_press;
  logic [15:0]        tf_hum;

  logic               th_vld;
  logic signed [15:0] th_temp;
  logic [16:0]        th_hum;

  logic               pre_vld;
  logic signed [63:0] pre_num;
  logic signed [30:0] pre_den;

  logic               div_vld;
  logic [63:0]        div_quo;
  logic               div_zero;

  logic               post_vld;
  logic [31:0]        post_press;
  logic               post_pvalid;

  // Temperature and humidity finish early and wait here for the pressure.
  logic signed [15:0] temp_dly_r [0:ALIGN_LAT-1];
  logic [16:0]        hum_dly_r  [0:ALIGN_LAT-1];

  // Configuration port: zero-wait writes, combinational read-back.
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[5:3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_coeffs_r <= '0;
      press_lo_r    <= '0;
      press_hi_r    <= '0;
      press_hum_r   <= '0;
      hum_r         <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_TEMP:      temp_coeffs_r <= pwdata[47:0];
        REG_PRESS_LO:  press_lo_r    <= pwdata;
        REG_PRESS_HI:  press_hi_r    <= pwdata;
        REG_PRESS_HUM: press_hum_r   <= pwdata[47:0];
        REG_HUM:       hum_r         <= pwdata[39:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_TEMP:      prdata = {16'b0, temp_coeffs_r};
      REG_PRESS_LO:  prdata = press_lo_r;
      REG_PRESS_HI:  prdata = press_hi_r;
      REG_PRESS_HUM: prdata = {16'b0, press_hum_r};
      REG_HUM:       prdata = {24'b0, hum_r};
      default:       prdata = '0;
    endcase
  end

  assign coef = '{temp_coeffs: temp_coeffs_r, press_lo: press_lo_r,
                  press_hi: press_hi_r, press_hum: press_hum_r, hum: hum_r};

  // The pipeline never stalls, so a new word is welcome in every cycle.
  assign busy = 1'b0;

  esc_tfine u_tfine (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vld    (start),
    .raw_temp  (in_raw_temp),
    .raw_press (in_raw_press),
    .raw_hum   (in_raw_hum),
    .coef      (coef),
    .out_vld   (tf_vld),
    .t_fine    (t_fine),
    .out_press (tf_press),
    .out_hum   (tf_hum)
  );

  esc_th u_th (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_vld     (tf_vld),
    .t_fine     (t_fine),
    .raw_hum    (tf_hum),
    .coef       (coef),
    .out_vld    (th_vld),
    .temp_centi (th_temp),
    .hum_q22_10 (th_hum)
  );

  esc_press_pre u_pre (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vld    (tf_vld),
    .t_fine    (t_fine),
    .raw_press (tf_press),
    .coef      (coef),
    .out_vld   (pre_vld),
    .num       (pre_num),
    .den       (pre_den)
  );

  esc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (pre_vld),
    .num      (pre_num),
    .den      (pre_den),
    .out_vld  (div_vld),
    .quo      (div_quo),
    .den_zero (div_zero)
  );

  esc_press_post u_post (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_vld      (div_vld),
    .quo         (div_quo),
    .den_zero    (div_zero),
    .coef        (coef),
    .out_vld     (post_vld),
    .press_q24_8 (post_press),
    .press_valid (post_pvalid)
  );

  // The delay line carries payload only; the pressure path's valid bit,
  // which has the same total depth, marks the finished word. The humidity
  // and temperature valid bit is not needed past this point.
  always_ff @(posedge clk) begin
    temp_dly_r[0] <= th_vld ? th_temp : temp_dly_r[0];
    hum_dly_r[0]  <= th_vld ? th_hum : hum_dly_r[0];
  end

  for (genvar i = 1; i < ALIGN_LAT; i++) begin : g_align
    always_ff @(posedge clk) begin
      temp_dly_r[i] <= temp_dly_r[i-1];
      hum_dly_r[i]  <= hum_dly_r[i-1];
    end
  end

  assign out_valid       = post_vld;
  assign out_temp_centi  = temp_dly_r[ALIGN_LAT-1];
  assign out_hum_q22_10  = hum_dly_r[ALIGN_LAT-1];
  assign out_press_q24_8 = post_press;
  assign out_press_valid = post_pvalid;

endmodule
`default_nettype wire
